// ===== design/periodic_monitor_scheduler_unit_macros.svh =====
// Assertion helpers for the scheduler block.
`ifndef PERIODIC_MONITOR_SCHEDULER_UNIT_MACROS_SVH
`define PERIODIC_MONITOR_SCHEDULER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// a holds at an edge -> b holds at the same edge
`define PMS_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: same-cycle implication");
// a holds at an edge -> b holds at the next edge
`define PMS_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: next-cycle implication");
`else
`define PMS_ASSERT_SAME(label, clk, rst, a, b)
`define PMS_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// ===== design/pms_pkg.sv =====
`timescale 1ns / 1ps
package pms_pkg;

   localparam int CAPACITY = 1024;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [1:0] CMD_CLEAR    = 2'd0;
   localparam logic [1:0] CMD_REGISTER = 2'd1;
   localparam logic [1:0] CMD_NEXT     = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [31:0] due;
      logic [31:0] id;
      logic [15:0] period;
   } entry_type;

   typedef struct packed {
      logic cmp_en;   // latch key-vs-entry compare
      logic upd_en;   // move the row one step
      logic pop;      // drop head and reinsert key, else plain insert
   } cell_ctl_type;

   // a is reported before b: earlier due, then smaller id, then smaller period
   function automatic logic entry_before(input entry_type a, input entry_type b);
      logic r;
      if (a.due != b.due) begin
         r = (a.due < b.due);
      end else if (a.id != b.id) begin
         r = (a.id < b.id);
      end else begin
         r = (a.period < b.period);
      end
      return r;
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] t, input logic [15:0] p);
      logic [32:0] s;
      s = {1'b0, t} + {17'b0, p};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// ===== design/pms_cell.sv =====
`timescale 1ns / 1ps
module pms_cell (
   input  logic                  clock,
   input  pms_pkg::cell_ctl_type ctl,
   input  pms_pkg::entry_type    key,
   input  logic                  cell_valid,
   input  pms_pkg::entry_type    prev_entry,
   input  logic                  prev_lt,
   input  pms_pkg::entry_type    next_entry,
   input  logic                  next_lt,
   output pms_pkg::entry_type    entry,
   output logic                  lt
);
   import pms_pkg::*;

   entry_type entry_ff, entry_in;
   logic      lt_ff, lt_in;

   // empty slots count as later than any key
   assign lt_in = !cell_valid || entry_before(key, entry_ff);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.pop) begin
         if (next_lt) begin
            entry_in = lt_ff ? entry_ff : key;
         end else begin
            entry_in = next_entry;
         end
      end else if (lt_ff) begin
         entry_in = prev_lt ? prev_entry : key;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cmp_en) begin
         lt_ff <= lt_in;
      end
      if (ctl.upd_en) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;

endmodule

// ===== design/periodic_monitor_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Periodic monitor scheduler. Monitors live in a sorted row of CAPACITY cells,
// earliest due first (ties: smaller id, then smaller period), so the head cell
// always holds the next monitor to report. Each transaction is taken in the
// idle state and answered with exactly one result: register and next go
// through accept, key build, compare broadcast to every cell, one-step shift
// of the row and result load; clear, unused codes, full and empty answers
// skip the compare and shift. Throughput is set by the compare-then-shift
// pass over the cell row, one transaction at a time. The result sits in an
// output register, so a new transaction is accepted while the previous result
// still waits on rsp_tready. No clearing pass: cell occupancy follows the
// entry count, which reset and clear set to zero.
`include "periodic_monitor_scheduler_unit_macros.svh"
module periodic_monitor_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // monitor_id [31:0], period [47:32]
   input  logic [1:0]  req_tuser,   // cmd [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // report_id [31:0], report_time [63:32]
   output logic [1:0]  rsp_tuser    // status [1:0]
);
   import pms_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_KEY   = 3'd1;
   localparam logic [2:0] ST_CMP   = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       cmd_ff;
   logic [31:0]      mid_ff;
   logic [15:0]      per_ff;
   entry_type        key_ff, key_in;
   logic [1:0]       pend_status_ff, pend_status_in;
   logic [31:0]      pend_id_ff, pend_id_in;
   logic [31:0]      pend_time_ff, pend_time_in;
   logic             rsp_valid_ff;
   logic [63:0]      rsp_data_ff;
   logic [1:0]       rsp_user_ff;
   logic             load_rsp;

   cell_ctl_type     ctl;
   entry_type        entry_w [CAPACITY];
   logic             lt_w    [CAPACITY];
   logic             valid_w [CAPACITY];

   assign req_tready = (state_ff == ST_IDLE);
   assign load_rsp   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // next state, key and pending result
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      key_in         = key_ff;
      pend_status_in = pend_status_ff;
      pend_id_in     = pend_id_ff;
      pend_time_in   = pend_time_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_KEY;
            end
         end
         ST_KEY: begin
            pend_status_in = STATUS_OK;
            pend_id_in     = 32'd0;
            pend_time_in   = 32'd0;
            state_in       = ST_DONE;
            case (cmd_ff)
               CMD_CLEAR: begin
                  count_in = '0;
               end
               CMD_REGISTER: begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     pend_status_in = STATUS_FULL;
                  end else begin
                     key_in   = '{due: {16'd0, per_ff}, id: mid_ff, period: per_ff};
                     state_in = ST_CMP;
                  end
               end
               CMD_NEXT: begin
                  if (count_ff == '0) begin
                     pend_status_in = STATUS_EMPTY;
                  end else begin
                     // head cell is the earliest monitor; it goes back in later
                     pend_id_in   = entry_w[0].id;
                     pend_time_in = entry_w[0].due;
                     key_in       = '{due: sat_add(entry_w[0].due, entry_w[0].period),
                                      id: entry_w[0].id, period: entry_w[0].period};
                     state_in     = ST_CMP;
                  end
               end
               default: begin
                  // unused code: no change, zero result
               end
            endcase
         end
         ST_CMP: begin
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (cmd_ff == CMD_REGISTER) begin
               count_in = count_ff + CNT_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl.cmp_en = (state_ff == ST_CMP);
      ctl.upd_en = (state_ff == ST_SHIFT);
      ctl.pop    = (cmd_ff == CMD_NEXT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff <= req_tuser;
         mid_ff <= req_tdata[31:0];
         per_ff <= req_tdata[47:32];
      end
      key_ff         <= key_in;
      pend_status_ff <= pend_status_in;
      pend_id_ff     <= pend_id_in;
      pend_time_ff   <= pend_time_in;
      if (load_rsp) begin
         rsp_data_ff <= {pend_time_ff, pend_id_ff};
         rsp_user_ff <= pend_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // sorted cell row; cell i is occupied while i is below the entry count
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type prev_e, next_e;
      logic      prev_l, next_l;

      assign valid_w[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign prev_e = key_ff;
         assign prev_l = 1'b0;
      end else begin : g_body
         assign prev_e = entry_w[i-1];
         assign prev_l = lt_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_e = entry_w[i];
         assign next_l = 1'b1;
      end else begin : g_mid
         assign next_e = entry_w[i+1];
         assign next_l = lt_w[i+1];
      end

      pms_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .key        (key_ff),
         .cell_valid (valid_w[i]),
         .prev_entry (prev_e),
         .prev_lt    (prev_l),
         .next_entry (next_e),
         .next_lt    (next_l),
         .entry      (entry_w[i]),
         .lt         (lt_w[i])
      );
   end

   // checks
   `PMS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `PMS_ASSERT_NEXT(a_accept_goes_key, clock, reset, req_tvalid && req_tready,
                    state_ff == ST_KEY)
   `PMS_ASSERT_SAME(a_head_sorted, clock, reset,
                    (state_ff == ST_IDLE) && (count_ff >= CNT_W'(2)),
                    !entry_before(entry_w[1], entry_w[0]))
   `PMS_ASSERT_SAME(a_fail_zero_report, clock, reset,
                    rsp_tvalid && (rsp_tuser != STATUS_OK), rsp_tdata == 64'd0)

endmodule
